/* rtl/core/inoise_pkg.sv */
// shared types, constants and arithmetic helpers for the improved noise block
`default_nettype none
package inoise_pkg;

  // fixed point format and table size
  localparam int FRAC_BITS     = 16;
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int POS_W         = 32;
  localparam int NOISE_W       = 18;

  // internal widths
  localparam int FADE_W = FRAC_BITS + 1;  // fade value in [0, 1]
  localparam int GW     = FRAC_BITS + 3;  // gradient and blend values
  localparam int DW     = FRAC_BITS + 4;  // blend difference
  localparam int QW     = FRAC_BITS + 4;  // quadratic part of the fade
  localparam int PW     = FADE_W + DW + 1;
  localparam int CW     = ((GW > NOISE_W) ? GW : NOISE_W) + 1;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  localparam logic signed [GW-1:0] ONE_FX  = GW'(1) << FRAC_BITS;
  localparam logic signed [CW-1:0] OUT_MAX = CW'((1 << (NOISE_W - 1)) - 1);
  localparam logic signed [CW-1:0] OUT_MIN = -CW'(1 << (NOISE_W - 1));

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  // one decoded word waiting in the queue
  typedef struct packed {
    op_t                  op;
    logic [IDX_W-1:0]     cx;
    logic [IDX_W-1:0]     cy;
    logic [IDX_W-1:0]     cz;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [FRAC_BITS-1:0] fz;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     val;
  } q_word_t;

  // one of twelve gradient directions dotted with the offset
  function automatic logic signed [GW-1:0] grad(logic [3:0] h,
                                                logic signed [GW-1:0] x,
                                                logic signed [GW-1:0] y,
                                                logic signed [GW-1:0] z);
    logic signed [GW-1:0] gu;
    logic signed [GW-1:0] gv;
    logic signed [GW-1:0] r;
    gu = (h < 4'd8) ? x : y;
    if (h < 4'd4) begin
      gv = y;
    end else if (h inside {4'd12, 4'd14}) begin
      gv = x;
    end else begin
      gv = z;
    end
    r = h[0] ? -gu : gu;
    r = h[1] ? (r - gv) : (r + gv);
    return r;
  endfunction

  // a + floor(t * (b - a) / one)
  function automatic logic signed [GW-1:0] lerp(logic [FADE_W-1:0] t,
                                                logic signed [GW-1:0] a,
                                                logic signed [GW-1:0] b);
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] sh;
    diff = DW'(b) - DW'(a);
    prod = $signed({1'b0, t}) * diff;
    sh   = prod >>> FRAC_BITS;
    return GW'(sh + PW'(a));
  endfunction

endpackage
`default_nettype wire

/* rtl/core/inoise_ram.sv */
// permutation table copy: one write port, two registered read ports
`default_nettype none
module inoise_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [inoise_pkg::IDX_W-1:0] waddr,
  input  wire logic [inoise_pkg::IDX_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [inoise_pkg::IDX_W-1:0] raddr_a,
  input  wire logic [inoise_pkg::IDX_W-1:0] raddr_b,
  output logic      [inoise_pkg::IDX_W-1:0] rdata_a,
  output logic      [inoise_pkg::IDX_W-1:0] rdata_b
);

  logic [inoise_pkg::IDX_W-1:0] mem [inoise_pkg::TABLE_ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, held while stalled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/inoise_front.sv */
// front end: takes input words, splits cell and fraction, queues them
`default_nettype none
module inoise_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          opcode,
  input  wire logic [inoise_pkg::POS_W-1:0]  pos_x,
  input  wire logic [inoise_pkg::POS_W-1:0]  pos_y,
  input  wire logic [inoise_pkg::POS_W-1:0]  pos_z,
  input  wire logic [inoise_pkg::IDX_W-1:0]  entry_index,
  input  wire logic [inoise_pkg::IDX_W-1:0]  entry_value,
  output inoise_pkg::q_word_t                q_head,
  output logic                               q_valid,
  input  wire logic                          q_pop
);

  localparam int F = inoise_pkg::FRAC_BITS;
  localparam int I = inoise_pkg::IDX_W;

  inoise_pkg::q_word_t                 mem [inoise_pkg::QDEPTH];
  inoise_pkg::q_word_t                 word;
  logic [inoise_pkg::QPW-1:0]          wr_ptr;
  logic [inoise_pkg::QPW-1:0]          rd_ptr;
  logic [inoise_pkg::QPW:0]            count;
  logic                                push;

  // decode the incoming word
  always_comb begin
    word     = '0;
    word.op  = inoise_pkg::op_t'(opcode);
    word.cx  = pos_x[F+I-1:F];
    word.cy  = pos_y[F+I-1:F];
    word.cz  = pos_z[F+I-1:F];
    word.fx  = pos_x[F-1:0];
    word.fy  = pos_y[F-1:0];
    word.fz  = pos_z[F-1:0];
    word.idx = entry_index;
    word.val = entry_value;
  end

  assign in_ready = (count != (inoise_pkg::QPW+1)'(inoise_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_head   = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= word;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/inoise_back.sv */
// back end: table lookups, fade, gradients and trilinear blend in a pipeline
`default_nettype none
module inoise_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  inoise_pkg::q_word_t                       q_head,
  input  wire logic                                 q_valid,
  output logic                                      q_pop,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [inoise_pkg::NOISE_W-1:0]     noise_value
);

  localparam int F  = inoise_pkg::FRAC_BITS;
  localparam int I  = inoise_pkg::IDX_W;
  localparam int GW = inoise_pkg::GW;
  localparam int FW = inoise_pkg::FADE_W;
  localparam int QW = inoise_pkg::QW;
  localparam int QX = 2 * F + 5;
  localparam int CW = inoise_pkg::CW;

  logic adv;

  // stage 1
  logic         s1_v, s1_ld;
  logic [I-1:0] s1_idx, s1_val, s1_cy, s1_cz;
  logic [F-1:0] s1_f [3];
  logic [2*F-1:0] s1_tt [3];
  // stage 2
  logic         s2_v, s2_ld;
  logic [I-1:0] s2_idx, s2_val, s2_cz;
  logic [F-1:0] s2_f [3];
  logic [QW-1:0] s2_q [3];
  logic [2*F-1:0] s2_t3p [3];
  // stage 3
  logic         s3_v, s3_ld;
  logic [F-1:0] s3_f [3];
  logic [F+QW-1:0] s3_fp [3];
  // stage 4
  logic         s4_v, s4_ld;
  logic signed [GW-1:0] s4_g [8];
  logic [FW-1:0] s4_u, s4_vv, s4_w;
  // stage 5
  logic         s5_v, s5_ld;
  logic signed [GW-1:0] s5_x [4];
  logic [FW-1:0] s5_vv, s5_w;
  // stage 6
  logic         s6_v, s6_ld;
  logic signed [GW-1:0] s6_y [2];
  logic [FW-1:0] s6_w;

  // table copy outputs
  logic [I-1:0] p0a, p0b, p1a, p1b, p2a, p2b;
  logic [I-1:0] h3a, h3b, h4a, h4b, h5a, h5b, h6a, h6b;
  logic [I-1:0] a_i, b_i, aa_i, ab_i, ba_i, bb_i;
  logic         we0, we1, we3;

  // combinational stage results
  logic [QW-1:0]      q_c [3];
  logic [2*F-1:0]     t3p_c [3];
  logic [F+QW-1:0]    fp_c [3];
  logic signed [GW-1:0] ox [2], oy [2], oz [2];
  logic signed [GW-1:0] r_c;
  logic signed [CW-1:0] r_x;

  // whole pipeline moves when the output slot is free or being taken
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && q_valid;

  assign we0 = q_pop && (q_head.op == inoise_pkg::OP_LOAD);
  assign we1 = adv && s1_v && s1_ld;
  assign we3 = adv && s2_v && s2_ld;

  // first lookup: cell x and x + 1
  inoise_ram u_ram0 (
    .clk(clk), .we(we0), .waddr(q_head.idx), .wdata(q_head.val), .re(adv),
    .raddr_a(q_head.cx), .raddr_b(q_head.cx + 1'b1), .rdata_a(p0a), .rdata_b(p0b)
  );

  assign a_i = p0a + s1_cy;
  assign b_i = p0b + s1_cy;

  // second lookup: a, a + 1, b, b + 1
  inoise_ram u_ram1 (
    .clk(clk), .we(we1), .waddr(s1_idx), .wdata(s1_val), .re(adv),
    .raddr_a(a_i), .raddr_b(a_i + 1'b1), .rdata_a(p1a), .rdata_b(p1b)
  );
  inoise_ram u_ram2 (
    .clk(clk), .we(we1), .waddr(s1_idx), .wdata(s1_val), .re(adv),
    .raddr_a(b_i), .raddr_b(b_i + 1'b1), .rdata_a(p2a), .rdata_b(p2b)
  );

  assign aa_i = p1a + s2_cz;
  assign ab_i = p1b + s2_cz;
  assign ba_i = p2a + s2_cz;
  assign bb_i = p2b + s2_cz;

  // corner hashes
  inoise_ram u_ram3 (
    .clk(clk), .we(we3), .waddr(s2_idx), .wdata(s2_val), .re(adv),
    .raddr_a(aa_i), .raddr_b(aa_i + 1'b1), .rdata_a(h3a), .rdata_b(h3b)
  );
  inoise_ram u_ram4 (
    .clk(clk), .we(we3), .waddr(s2_idx), .wdata(s2_val), .re(adv),
    .raddr_a(ab_i), .raddr_b(ab_i + 1'b1), .rdata_a(h4a), .rdata_b(h4b)
  );
  inoise_ram u_ram5 (
    .clk(clk), .we(we3), .waddr(s2_idx), .wdata(s2_val), .re(adv),
    .raddr_a(ba_i), .raddr_b(ba_i + 1'b1), .rdata_a(h5a), .rdata_b(h5b)
  );
  inoise_ram u_ram6 (
    .clk(clk), .we(we3), .waddr(s2_idx), .wdata(s2_val), .re(adv),
    .raddr_a(bb_i), .raddr_b(bb_i + 1'b1), .rdata_a(h6a), .rdata_b(h6b)
  );

  // fade arithmetic and corner offsets
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [QX-1:0] qs;
      qs = QX'(s1_tt[k]) * QX'(6) + (QX'(10) << (2 * F))
           - QX'(15) * (QX'(s1_f[k]) << F);
      q_c[k]   = qs[F+QW-1:F];
      t3p_c[k] = s1_tt[k][2*F-1:F] * s1_f[k];
      fp_c[k]  = s2_t3p[k][2*F-1:F] * s2_q[k];
    end
    ox[0] = $signed({3'b000, s3_f[0]});
    oy[0] = $signed({3'b000, s3_f[1]});
    oz[0] = $signed({3'b000, s3_f[2]});
    ox[1] = ox[0] - inoise_pkg::ONE_FX;
    oy[1] = oy[0] - inoise_pkg::ONE_FX;
    oz[1] = oz[0] - inoise_pkg::ONE_FX;
  end

  // final blend and saturation
  always_comb begin
    r_c = inoise_pkg::lerp(s6_w, s6_y[0], s6_y[1]);
    r_x = CW'(r_c);
    if (r_x > inoise_pkg::OUT_MAX) begin
      r_x = inoise_pkg::OUT_MAX;
    end else if (r_x < inoise_pkg::OUT_MIN) begin
      r_x = inoise_pkg::OUT_MIN;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      s5_v      <= 1'b0;
      s6_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= q_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      s5_v      <= s4_v;
      s6_v      <= s5_v;
      out_valid <= s6_v && !s6_ld;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ld  <= (q_head.op == inoise_pkg::OP_LOAD);
      s1_idx <= q_head.idx;
      s1_val <= q_head.val;
      s1_cy  <= q_head.cy;
      s1_cz  <= q_head.cz;
      s1_f[0] <= q_head.fx;
      s1_f[1] <= q_head.fy;
      s1_f[2] <= q_head.fz;
      s1_tt[0] <= q_head.fx * q_head.fx;
      s1_tt[1] <= q_head.fy * q_head.fy;
      s1_tt[2] <= q_head.fz * q_head.fz;

      s2_ld  <= s1_ld;
      s2_idx <= s1_idx;
      s2_val <= s1_val;
      s2_cz  <= s1_cz;
      s2_f   <= s1_f;
      s2_q   <= q_c;
      s2_t3p <= t3p_c;

      s3_ld <= s2_ld;
      s3_f  <= s2_f;
      s3_fp <= fp_c;

      s4_ld   <= s3_ld;
      s4_u    <= s3_fp[0][F+FW-1:F];
      s4_vv   <= s3_fp[1][F+FW-1:F];
      s4_w    <= s3_fp[2][F+FW-1:F];
      s4_g[0] <= inoise_pkg::grad(h3a[3:0], ox[0], oy[0], oz[0]);
      s4_g[1] <= inoise_pkg::grad(h5a[3:0], ox[1], oy[0], oz[0]);
      s4_g[2] <= inoise_pkg::grad(h4a[3:0], ox[0], oy[1], oz[0]);
      s4_g[3] <= inoise_pkg::grad(h6a[3:0], ox[1], oy[1], oz[0]);
      s4_g[4] <= inoise_pkg::grad(h3b[3:0], ox[0], oy[0], oz[1]);
      s4_g[5] <= inoise_pkg::grad(h5b[3:0], ox[1], oy[0], oz[1]);
      s4_g[6] <= inoise_pkg::grad(h4b[3:0], ox[0], oy[1], oz[1]);
      s4_g[7] <= inoise_pkg::grad(h6b[3:0], ox[1], oy[1], oz[1]);

      s5_ld   <= s4_ld;
      s5_vv   <= s4_vv;
      s5_w    <= s4_w;
      s5_x[0] <= inoise_pkg::lerp(s4_u, s4_g[0], s4_g[1]);
      s5_x[1] <= inoise_pkg::lerp(s4_u, s4_g[2], s4_g[3]);
      s5_x[2] <= inoise_pkg::lerp(s4_u, s4_g[4], s4_g[5]);
      s5_x[3] <= inoise_pkg::lerp(s4_u, s4_g[6], s4_g[7]);

      s6_ld   <= s5_ld;
      s6_w    <= s5_w;
      s6_y[0] <= inoise_pkg::lerp(s5_vv, s5_x[0], s5_x[1]);
      s6_y[1] <= inoise_pkg::lerp(s5_vv, s5_x[2], s5_x[3]);

      noise_value <= r_x[inoise_pkg::NOISE_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/improved_noise_3d.sv */
// top level of the 3-d improved gradient noise block
// One word is taken per cycle and a sample word gives one noise value per cycle
// when the output side keeps up. A load word writes one byte of the 256-entry
// permutation table (into each of its seven copies as it passes) and gives no
// output. A sample word waits in a four-word queue behind the input and then
// runs through a seven-register back pipeline, whose depth is set by the three
// chained table lookups, each a registered read, and by the fade and blend
// multiplies. The table must be fully loaded before samples are sent; its
// contents are undefined after reset.
`default_nettype none
module improved_noise_3d (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                opcode,
  input  wire logic signed [inoise_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [inoise_pkg::POS_W-1:0] pos_y,
  input  wire logic signed [inoise_pkg::POS_W-1:0] pos_z,
  input  wire logic [inoise_pkg::IDX_W-1:0]        entry_index,
  input  wire logic [inoise_pkg::IDX_W-1:0]        entry_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [inoise_pkg::NOISE_W-1:0]    noise_value
);

  inoise_pkg::q_word_t q_head;
  logic                q_valid;
  logic                q_pop;

  // input decode and queue
  inoise_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .entry_index(entry_index), .entry_value(entry_value),
    .q_head(q_head), .q_valid(q_valid), .q_pop(q_pop)
  );

  // noise pipeline
  inoise_back u_back (
    .clk(clk), .rst(rst), .q_head(q_head), .q_valid(q_valid), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value)
  );

endmodule
`default_nettype wire
